>>> src/hem_pkg.sv
package hem_pkg;

  localparam int NUM_LEVELS = 256;
  localparam int BIN_W      = $clog2(NUM_LEVELS);
  localparam int CNT_W      = 25;
  localparam int PIX_W      = 8;
  localparam int LVL_W      = 8;
  localparam int PROD_W     = CNT_W + LVL_W;

  localparam logic [CNT_W-1:0] SUM_MAX    = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] AREA_RESET = CNT_W'(4096);
  localparam logic [LVL_W-1:0] LEVEL_MAX  = {LVL_W{1'b1}};

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MAP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] bin_count;
    logic [PIX_W-1:0] pixel;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // pixel values past the end of the table map to the last entry
  function automatic logic [BIN_W-1:0] pix_index(input logic [PIX_W-1:0] pix);
    logic [BIN_W-1:0] idx;
    if (int'(pix) < NUM_LEVELS) begin
      idx = BIN_W'(pix);
    end else begin
      idx = BIN_W'(NUM_LEVELS - 1);
    end
    return idx;
  endfunction

endpackage

>>> src/hem_if.sv
interface hem_in_if;
  import hem_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [CNT_W-1:0] bin_count;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, cmd, bin_count, pixel, input ready);
  modport sink (input valid, cmd, bin_count, pixel, output ready);
endinterface

interface hem_out_if;
  import hem_pkg::*;
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] level;
  logic             clipped;
  modport source (output valid, level, clipped, input ready);
  modport sink (input valid, level, clipped, output ready);
endinterface

interface hem_cfg_if;
  import hem_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> src/histogram_equalization_map_core.sv
// Histogram equalization: builds a level table from histogram bins, then
// maps pixels through it.
// Channels (valid/ready, transaction when both high at a clock edge):
//   req : cmd 0 loads the next bin count, cmd 1 maps a pixel value.
//   rsp : one transaction per req transaction, in order: level, clipped.
//   cfg : writes region_area, always ready; write only while idle.
// A 4-entry queue sits between request intake and the execution engine,
// so req keeps flowing while the engine is busy or rsp is stalled.
// Pixel map: 1 per cycle sustained while no bin load runs and rsp is not
// stalled; path from req to rsp valid: queue, table read, output register.
// Bin load: saturated sum, scale compare, then a restoring divider
// producing one level bit per cycle (skipped when the scaled sum clips),
// then the table write. The divider sets the load rate.
// Reset (synchronous) empties the queue and pipeline, clears the running
// sum and bin counter, and sets region_area to 4096. Table contents are
// undefined until the first full load. A stalled rsp holds its data; the
// pipeline and then the queue fill, after which req.ready drops.
module histogram_equalization_map_core
  import hem_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  hem_in_if.sink    req,
  hem_out_if.source rsp,
  hem_cfg_if.sink   cfg
);

  q_head_t head;
  logic    pop;

  hem_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (pop)
  );

  hem_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .cfg  (cfg),
    .rsp  (rsp)
  );

endmodule

>>> src/hem_front.sv
module hem_front
  import hem_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  hem_in_if.sink  req,
  output q_head_t head,
  input  logic    pop
);

  q_item_t            queue [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic [Q_PTR_W:0]   count_next;
  logic               push;
  q_item_t            item_in;

  assign req.ready = (count != (Q_PTR_W+1)'(Q_DEPTH));
  assign push      = req.valid && req.ready;

  always_comb begin
    item_in.op        = op_t'(req.cmd);
    item_in.bin_count = req.bin_count;
    item_in.pixel     = req.pixel;
  end

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item_in;
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = queue[rd_ptr];

endmodule

>>> src/hem_back.sv
module hem_back
  import hem_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  q_head_t  head,
  output logic     pop,
  hem_cfg_if.sink  cfg,
  hem_out_if.source rsp
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCALE = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] region_area;
  logic [CNT_W-1:0] running_sum;
  logic [BIN_W-1:0] next_bin;

  logic [CNT_W-1:0] load_sum;
  logic [CNT_W-1:0] area_q;
  logic [CNT_W-1:0] rem;
  logic [LVL_W-1:0] low_bits;
  logic [LVL_W-1:0] quo;
  logic [2:0]       step;
  logic             clip_q;

  logic             s1_valid;
  logic             s1_load;
  logic [LVL_W-1:0] s1_level;
  logic             s1_clip;
  logic [LVL_W-1:0] rd_data;
  logic [LVL_W-1:0] level_table [NUM_LEVELS];

  logic             out_valid;
  logic [LVL_W-1:0] out_level;
  logic             out_clipped;

  logic             out_free;
  logic             s1_free;
  logic             map_pop;
  logic             load_pop;
  logic             load_done;
  logic [CNT_W:0]   sum_wide;
  logic [PROD_W-1:0] prod;
  logic             over;
  logic [CNT_W:0]   trial;
  logic             q_bit;

  assign cfg.ready = 1'b1;

  assign out_free  = !out_valid || rsp.ready;
  assign s1_free   = !s1_valid || out_free;
  assign map_pop   = (state == ST_IDLE) && head.valid && (head.item.op == OP_MAP) && s1_free;
  assign load_pop  = (state == ST_IDLE) && head.valid && (head.item.op == OP_LOAD);
  assign pop       = map_pop || load_pop;
  assign load_done = (state == ST_DONE) && s1_free;

  assign sum_wide = {1'b0, running_sum} + {1'b0, head.item.bin_count};
  // 255 * sum as (sum << 8) - sum
  assign prod  = {load_sum, {LVL_W{1'b0}}} - {{LVL_W{1'b0}}, load_sum};
  assign over  = prod >= {area_q, {LVL_W{1'b0}}};
  assign trial = {rem, low_bits[LVL_W-1]};
  assign q_bit = trial >= {1'b0, area_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      region_area <= AREA_RESET;
      running_sum <= '0;
      next_bin    <= '0;
    end else begin
      if (cfg.valid) begin
        region_area <= cfg.data;
      end
      unique case (state)
        ST_IDLE: begin
          if (load_pop) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= over ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          if (step == 3'd7) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (s1_free) begin
            state <= ST_IDLE;
            if (next_bin == BIN_W'(NUM_LEVELS - 1)) begin
              next_bin    <= '0;
              running_sum <= '0;
            end else begin
              next_bin    <= next_bin + 1'b1;
              running_sum <= load_sum;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // divider datapath: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (load_pop) begin
      load_sum <= sum_wide[CNT_W] ? SUM_MAX : sum_wide[CNT_W-1:0];
      area_q   <= (region_area == '0) ? CNT_W'(1) : region_area;
    end
    if (state == ST_SCALE) begin
      rem      <= prod[PROD_W-1:LVL_W];
      low_bits <= prod[LVL_W-1:0];
      step     <= '0;
      quo      <= over ? LEVEL_MAX : '0;
      clip_q   <= over;
    end
    if (state == ST_DIV) begin
      rem      <= q_bit ? CNT_W'(trial - {1'b0, area_q}) : trial[CNT_W-1:0];
      low_bits <= {low_bits[LVL_W-2:0], 1'b0};
      quo      <= {quo[LVL_W-2:0], q_bit};
      step     <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_done) begin
      level_table[next_bin] <= quo;
    end
    if (map_pop) begin
      rd_data <= level_table[pix_index(head.item.pixel)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= map_pop || load_done;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_load  <= load_done;
      s1_level <= quo;
      s1_clip  <= clip_q;
    end
    if (out_free) begin
      out_level   <= s1_load ? s1_level : rd_data;
      out_clipped <= s1_load && s1_clip;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.level   = out_level;
  assign rsp.clipped = out_clipped;

endmodule

>>> src/hem_checker.sv
module hem_checker
  import hem_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [LVL_W-1:0] rsp_level,
  input logic             rsp_clipped,
  input logic             cfg_ready
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level) && $stable(rsp_clipped))
    else $error("rsp dropped or changed while stalled");

  a_clip_level: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_clipped |-> rsp_level == LEVEL_MAX)
    else $error("clipped result without saturated level");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("rsp valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("cfg not ready");

endmodule

bind histogram_equalization_map_core hem_checker u_hem_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_level   (rsp.level),
  .rsp_clipped (rsp.clipped),
  .cfg_ready   (cfg.ready)
);
